FILE: src/four_wheel_diff_drive_odometry_unit_macros.svh
`ifndef FOUR_WHEEL_DIFF_DRIVE_ODOMETRY_UNIT_MACROS_SVH
`define FOUR_WHEEL_DIFF_DRIVE_ODOMETRY_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define FDO_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdo check failed");

// consequent checked in the next cycle
`define FDO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdo check failed");

`endif

FILE: src/fdo_pkg.sv
`timescale 1ns / 1ps

package fdo_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam int ROM_IDX_W = 6;

   // shared multiplier: 64 x 16 per cycle, top chunk of b first
   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 48;
   localparam int MUL_CHUNK_W = 16;
   localparam int MUL_CHUNKS = MUL_B_W / MUL_CHUNK_W;
   localparam int MUL_CNT_W = 2;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int ANG_W = 49;
   localparam int CS_W = 36;
   localparam int RED_W = 51;
   localparam int RED_STEPS = 15;
   localparam int RED_K_W = 4;

   localparam logic [34:0] TWO_PI_U = 35'd26986075409;
   localparam logic [RED_W-1:0] RED_OFFSET = RED_W'(TWO_PI_U) << (RED_STEPS - 1);
   localparam logic signed [CS_W-1:0] TWO_PI_S = 36'sd26986075409;
   localparam logic signed [CS_W-1:0] PI_S = 36'sd13493037705;
   localparam logic signed [CS_W-1:0] HALF_PI_S = 36'sd6746518852;
   localparam logic signed [CS_W-1:0] CORDIC_GAIN = 36'sd2608131496;

   localparam logic [1:0] CSR_METERS_PER_TICK = 2'd0;
   localparam logic [1:0] CSR_INV_WHEELBASE = 2'd1;

   localparam logic [31:0] MPT_RESET = 32'd7906076;
   localparam logic [23:0] IVW_RESET = 24'd65536;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL_D,
      ST_MUL_P,
      ST_MUL_TH,
      ST_MID,
      ST_ROT,
      ST_MUL_X,
      ST_MUL_Y,
      ST_OUT
   } fdo_state_type;

   typedef enum logic [2:0] {
      CR_IDLE,
      CR_REDUCE,
      CR_FOLD,
      CR_ROTATE,
      CR_DONE
   } fdo_cordic_state_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } fdo_mul_req_type;

   typedef struct packed {
      logic                   done;
      logic signed [CS_W-1:0] cos_val;
      logic signed [CS_W-1:0] sin_val;
   } fdo_cordic_rsp_type;

   // atan(2^-i), Q.32
   function automatic logic [31:0] atan_rom(input logic [ROM_IDX_W-1:0] i);
      logic [31:0] v;
      unique case (i)
         6'd0:    v = 32'd3373259426;
         6'd1:    v = 32'd1991351318;
         6'd2:    v = 32'd1052175346;
         6'd3:    v = 32'd534100635;
         6'd4:    v = 32'd268086748;
         6'd5:    v = 32'd134174063;
         6'd6:    v = 32'd67103403;
         6'd7:    v = 32'd33553749;
         6'd8:    v = 32'd16777131;
         6'd9:    v = 32'd8388597;
         6'd10:   v = 32'd4194303;
         6'd11:   v = 32'd2097152;
         6'd12:   v = 32'd1048576;
         6'd13:   v = 32'd524288;
         6'd14:   v = 32'd262144;
         6'd15:   v = 32'd131072;
         6'd16:   v = 32'd65536;
         6'd17:   v = 32'd32768;
         6'd18:   v = 32'd16384;
         6'd19:   v = 32'd8192;
         6'd20:   v = 32'd4096;
         6'd21:   v = 32'd2048;
         6'd22:   v = 32'd1024;
         6'd23:   v = 32'd512;
         6'd24:   v = 32'd256;
         6'd25:   v = 32'd128;
         6'd26:   v = 32'd64;
         6'd27:   v = 32'd32;
         6'd28:   v = 32'd16;
         6'd29:   v = 32'd8;
         6'd30:   v = 32'd4;
         6'd31:   v = 32'd2;
         6'd32:   v = 32'd1;
         6'd33:   v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: src/fdo_mul.sv
`timescale 1ns / 1ps

module fdo_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  fdo_pkg::fdo_mul_req_type        req,
   output logic                            done,
   output logic [fdo_pkg::MUL_P_W-1:0]     prod
);

   logic [fdo_pkg::MUL_A_W-1:0] a_ff, a_in;
   logic [fdo_pkg::MUL_B_W-1:0] b_ff, b_in;
   logic [fdo_pkg::MUL_P_W-1:0] acc_ff, acc_in;
   logic [fdo_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [fdo_pkg::MUL_A_W+fdo_pkg::MUL_CHUNK_W-1:0] part;

   always_comb begin
      part = a_ff * b_ff[fdo_pkg::MUL_B_W-1 -: fdo_pkg::MUL_CHUNK_W];
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in = req.a;
         b_in = req.b;
         acc_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift-accumulate, most significant chunk first
         acc_in = {acc_ff[fdo_pkg::MUL_P_W-fdo_pkg::MUL_CHUNK_W-1:0],
                   {fdo_pkg::MUL_CHUNK_W{1'b0}}}
                  + fdo_pkg::MUL_P_W'(part);
         b_in = {b_ff[fdo_pkg::MUL_B_W-fdo_pkg::MUL_CHUNK_W-1:0],
                 {fdo_pkg::MUL_CHUNK_W{1'b0}}};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fdo_pkg::MUL_CNT_W'(fdo_pkg::MUL_CHUNKS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

FILE: src/fdo_cordic.sv
`timescale 1ns / 1ps

module fdo_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [fdo_pkg::ANG_W-1:0]    angle,
   output fdo_pkg::fdo_cordic_rsp_type         rsp
);

   fdo_pkg::fdo_cordic_state_type state_ff, state_in;
   logic [fdo_pkg::RED_W-1:0] v_ff, v_in;
   logic [fdo_pkg::RED_K_W-1:0] k_ff, k_in;
   logic signed [fdo_pkg::CS_W-1:0] x_ff, x_in, y_ff, y_in, r_ff, r_in;
   logic flip_ff, flip_in;
   logic [fdo_pkg::STEP_W-1:0] step_ff, step_in;

   logic [fdo_pkg::RED_W-1:0] red_sub;
   logic signed [fdo_pkg::CS_W-1:0] r0, r1, r2, xs, ys, atan_val;
   logic flip_fold;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdo_pkg::CR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      v_ff <= v_in;
      k_ff <= k_in;
      x_ff <= x_in;
      y_ff <= y_in;
      r_ff <= r_in;
      flip_ff <= flip_in;
      step_ff <= step_in;
   end

   always_comb begin
      red_sub = fdo_pkg::RED_W'(fdo_pkg::TWO_PI_U) << k_ff;

      // fold into (-pi, pi], then into [-pi/2, pi/2] with sign flip
      r0 = fdo_pkg::CS_W'(v_ff);
      r1 = (r0 > fdo_pkg::PI_S) ? r0 - fdo_pkg::TWO_PI_S : r0;
      r2 = r1;
      flip_fold = 1'b0;
      if (r1 > fdo_pkg::HALF_PI_S) begin
         r2 = r1 - fdo_pkg::PI_S;
         flip_fold = 1'b1;
      end else if (r1 < -fdo_pkg::HALF_PI_S) begin
         r2 = r1 + fdo_pkg::PI_S;
         flip_fold = 1'b1;
      end

      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      atan_val = $signed(fdo_pkg::CS_W'(fdo_pkg::atan_rom(fdo_pkg::ROM_IDX_W'(step_ff))));

      state_in = state_ff;
      v_in = v_ff;
      k_in = k_ff;
      x_in = x_ff;
      y_in = y_ff;
      r_in = r_ff;
      flip_in = flip_ff;
      step_in = step_ff;

      unique case (state_ff)
         fdo_pkg::CR_IDLE: begin
            if (start) begin
               // bias by a multiple of 2pi so the remainder search runs unsigned
               v_in = fdo_pkg::RED_W'(angle) + fdo_pkg::RED_OFFSET;
               k_in = fdo_pkg::RED_K_W'(fdo_pkg::RED_STEPS - 1);
               state_in = fdo_pkg::CR_REDUCE;
            end
         end
         fdo_pkg::CR_REDUCE: begin
            if (v_ff >= red_sub) begin
               v_in = v_ff - red_sub;
            end
            k_in = k_ff - 1'b1;
            if (k_ff == '0) begin
               state_in = fdo_pkg::CR_FOLD;
            end
         end
         fdo_pkg::CR_FOLD: begin
            r_in = r2;
            flip_in = flip_fold;
            x_in = fdo_pkg::CORDIC_GAIN;
            y_in = '0;
            step_in = '0;
            state_in = fdo_pkg::CR_ROTATE;
         end
         fdo_pkg::CR_ROTATE: begin
            if (r_ff >= 0) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               r_in = r_ff - atan_val;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               r_in = r_ff + atan_val;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == fdo_pkg::STEP_W'(fdo_pkg::CORDIC_STEPS - 1)) begin
               state_in = fdo_pkg::CR_DONE;
            end
         end
         fdo_pkg::CR_DONE: begin
            state_in = fdo_pkg::CR_IDLE;
         end
         default: begin
            state_in = fdo_pkg::CR_IDLE;
         end
      endcase
   end

   assign rsp.done = (state_ff == fdo_pkg::CR_DONE);
   assign rsp.cos_val = flip_ff ? -x_ff : x_ff;
   assign rsp.sin_val = flip_ff ? -y_ff : y_ff;

endmodule

FILE: src/four_wheel_diff_drive_odometry_unit.sv
`timescale 1ns / 1ps
// Wheel odometry for a four-wheel differential drive. Each word on req_ carries a
// millisecond timestamp and four cumulative encoder counts; the first word after
// reset only primes the stored counts and zeroes the pose, every later word
// returns one rsp_ word with the timestamp and the pose (x, y in signed Q32.16 m,
// heading in signed Q16.32 rad, all saturating). The block works on one word at
// a time: from accept to result, a word passes through five products on the
// shared 64x16 multiplier, a 15-step remainder search that brings the midpoint
// heading into range, and one CORDIC rotation per cycle. A finished word waits
// in the output register; req_stall stays high while a word is in flight.
// csr_ writes are always ready and should only be issued while the block is idle.

`include "four_wheel_diff_drive_odometry_unit_macros.svh"

module four_wheel_diff_drive_odometry_unit (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_timestamp_ms,
   input  logic signed [31:0] req_front_left_ticks,
   input  logic signed [31:0] req_front_right_ticks,
   input  logic signed [31:0] req_rear_left_ticks,
   input  logic signed [31:0] req_rear_right_ticks,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_pose_time_ms,
   output logic signed [47:0] rsp_pose_x,
   output logic signed [47:0] rsp_pose_y,
   output logic signed [47:0] rsp_heading,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam logic signed [49:0] MAX47 = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [49:0] MIN47 = -50'sh0_8000_0000_0000;

   function automatic logic [47:0] cap48(input logic [fdo_pkg::MUL_P_W-1:0] v);
      logic [47:0] r;
      r = (|v[fdo_pkg::MUL_P_W-1:48]) ? '1 : v[47:0];
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      logic signed [47:0] r;
      if (v > MAX47) begin
         r = MAX47[47:0];
      end else if (v < MIN47) begin
         r = MIN47[47:0];
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

   fdo_pkg::fdo_state_type state_ff, state_in;
   logic have_prev_ff, have_prev_in;
   logic issued_ff, issued_in;
   logic [31:0] mpt_ff, mpt_in;
   logic [23:0] ivw_ff, ivw_in;

   logic [31:0] prev_fl_ff, prev_fl_in, prev_fr_ff, prev_fr_in;
   logic [31:0] prev_rl_ff, prev_rl_in, prev_rr_ff, prev_rr_in;
   logic [31:0] time_ff, time_in;
   logic signed [32:0] sl_ff, sl_in, sr_ff, sr_in;
   logic signed [33:0] s_ff, s_in, dd_ff, dd_in;
   logic signed [48:0] d_ff, d_in, dth_ff, dth_in, mid_ff, mid_in;
   logic [57:0] p_ff, p_in;
   logic signed [fdo_pkg::CS_W-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [47:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, head_ff, head_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_time_ff, rsp_time_in;
   logic signed [47:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_head_ff, rsp_head_in;

   logic signed [31:0] dfl, dfr, drl, drr;
   logic [33:0] s_mag, dd_mag;
   logic [48:0] d_mag;
   logic [fdo_pkg::CS_W-1:0] cos_mag, sin_mag;
   logic [47:0] r48;
   logic signed [48:0] r49, term;
   logic mul_state;

   fdo_pkg::fdo_mul_req_type mul_req;
   logic mul_done;
   logic [fdo_pkg::MUL_P_W-1:0] mul_prod;
   logic cordic_start;
   fdo_pkg::fdo_cordic_rsp_type cordic_rsp;

   fdo_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   fdo_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (mid_ff),
      .rsp   (cordic_rsp)
   );

   assign req_stall = (state_ff != fdo_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdo_pkg::ST_IDLE;
         have_prev_ff <= 1'b0;
         issued_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mpt_ff <= fdo_pkg::MPT_RESET;
         ivw_ff <= fdo_pkg::IVW_RESET;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         head_ff <= '0;
      end else begin
         state_ff <= state_in;
         have_prev_ff <= have_prev_in;
         issued_ff <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         mpt_ff <= mpt_in;
         ivw_ff <= ivw_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         head_ff <= head_in;
      end
      prev_fl_ff <= prev_fl_in;
      prev_fr_ff <= prev_fr_in;
      prev_rl_ff <= prev_rl_in;
      prev_rr_ff <= prev_rr_in;
      time_ff <= time_in;
      sl_ff <= sl_in;
      sr_ff <= sr_in;
      s_ff <= s_in;
      dd_ff <= dd_in;
      d_ff <= d_in;
      p_ff <= p_in;
      dth_ff <= dth_in;
      mid_ff <= mid_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
      rsp_time_ff <= rsp_time_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_head_ff <= rsp_head_in;
   end

   always_comb begin
      dfl = req_front_left_ticks - prev_fl_ff;
      dfr = req_front_right_ticks - prev_fr_ff;
      drl = req_rear_left_ticks - prev_rl_ff;
      drr = req_rear_right_ticks - prev_rr_ff;

      s_mag = s_ff[33] ? 34'(-s_ff) : 34'(s_ff);
      dd_mag = dd_ff[33] ? 34'(-dd_ff) : 34'(dd_ff);
      d_mag = d_ff[48] ? 49'(-d_ff) : 49'(d_ff);
      cos_mag = cos_ff[fdo_pkg::CS_W-1] ? fdo_pkg::CS_W'(-cos_ff) : fdo_pkg::CS_W'(cos_ff);
      sin_mag = sin_ff[fdo_pkg::CS_W-1] ? fdo_pkg::CS_W'(-sin_ff) : fdo_pkg::CS_W'(sin_ff);

      r48 = '0;
      r49 = '0;
      term = '0;

      state_in = state_ff;
      have_prev_in = have_prev_ff;
      issued_in = issued_ff;
      mpt_in = mpt_ff;
      ivw_in = ivw_ff;
      prev_fl_in = prev_fl_ff;
      prev_fr_in = prev_fr_ff;
      prev_rl_in = prev_rl_ff;
      prev_rr_in = prev_rr_ff;
      time_in = time_ff;
      sl_in = sl_ff;
      sr_in = sr_ff;
      s_in = s_ff;
      dd_in = dd_ff;
      d_in = d_ff;
      p_in = p_ff;
      dth_in = dth_ff;
      mid_in = mid_ff;
      cos_in = cos_ff;
      sin_in = sin_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      head_in = head_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_time_in = rsp_time_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_head_in = rsp_head_ff;

      mul_state = (state_ff == fdo_pkg::ST_MUL_D) || (state_ff == fdo_pkg::ST_MUL_P)
                  || (state_ff == fdo_pkg::ST_MUL_TH) || (state_ff == fdo_pkg::ST_MUL_X)
                  || (state_ff == fdo_pkg::ST_MUL_Y);
      mul_req.start = mul_state && !issued_ff;
      mul_req.a = '0;
      mul_req.b = '0;
      cordic_start = (state_ff == fdo_pkg::ST_ROT) && !issued_ff;
      if (mul_req.start || cordic_start) begin
         issued_in = 1'b1;
      end

      if (csr_valid) begin
         if (csr_index == fdo_pkg::CSR_METERS_PER_TICK) begin
            mpt_in = csr_wdata;
         end else if (csr_index == fdo_pkg::CSR_INV_WHEELBASE) begin
            ivw_in = csr_wdata[23:0];
         end
      end

      unique case (state_ff)
         fdo_pkg::ST_IDLE: begin
            if (req_valid) begin
               prev_fl_in = req_front_left_ticks;
               prev_fr_in = req_front_right_ticks;
               prev_rl_in = req_rear_left_ticks;
               prev_rr_in = req_rear_right_ticks;
               if (have_prev_ff) begin
                  time_in = req_timestamp_ms;
                  sl_in = 33'(dfl) + 33'(drl);
                  sr_in = 33'(dfr) + 33'(drr);
                  state_in = fdo_pkg::ST_SUM;
               end else begin
                  // priming word: no result
                  have_prev_in = 1'b1;
                  pos_x_in = '0;
                  pos_y_in = '0;
                  head_in = '0;
               end
            end
         end
         fdo_pkg::ST_SUM: begin
            s_in = 34'(sl_ff) + 34'(sr_ff);
            dd_in = 34'(sr_ff) - 34'(sl_ff);
            state_in = fdo_pkg::ST_MUL_D;
         end
         fdo_pkg::ST_MUL_D: begin
            mul_req.a = fdo_pkg::MUL_A_W'(s_mag);
            mul_req.b = fdo_pkg::MUL_B_W'(mpt_ff);
            if (mul_done) begin
               r48 = cap48(mul_prod >> 18);
               r49 = $signed({1'b0, r48});
               d_in = s_ff[33] ? -r49 : r49;
               issued_in = 1'b0;
               state_in = fdo_pkg::ST_MUL_P;
            end
         end
         fdo_pkg::ST_MUL_P: begin
            mul_req.a = fdo_pkg::MUL_A_W'(dd_mag);
            mul_req.b = fdo_pkg::MUL_B_W'(ivw_ff);
            if (mul_done) begin
               p_in = mul_prod[57:0];
               issued_in = 1'b0;
               state_in = fdo_pkg::ST_MUL_TH;
            end
         end
         fdo_pkg::ST_MUL_TH: begin
            mul_req.a = fdo_pkg::MUL_A_W'(p_ff);
            mul_req.b = fdo_pkg::MUL_B_W'(mpt_ff);
            if (mul_done) begin
               r48 = cap48(mul_prod >> 17);
               r49 = $signed({1'b0, r48});
               dth_in = dd_ff[33] ? -r49 : r49;
               issued_in = 1'b0;
               state_in = fdo_pkg::ST_MID;
            end
         end
         fdo_pkg::ST_MID: begin
            // midpoint heading for the rotation
            mid_in = 49'(head_ff) + (dth_ff >>> 1);
            state_in = fdo_pkg::ST_ROT;
         end
         fdo_pkg::ST_ROT: begin
            if (cordic_rsp.done) begin
               cos_in = cordic_rsp.cos_val;
               sin_in = cordic_rsp.sin_val;
               issued_in = 1'b0;
               state_in = fdo_pkg::ST_MUL_X;
            end
         end
         fdo_pkg::ST_MUL_X: begin
            mul_req.a = fdo_pkg::MUL_A_W'(d_mag);
            mul_req.b = fdo_pkg::MUL_B_W'(cos_mag);
            if (mul_done) begin
               r48 = cap48(mul_prod >> 32);
               r49 = $signed({1'b0, r48});
               term = (d_ff[48] ^ cos_ff[fdo_pkg::CS_W-1]) ? -r49 : r49;
               pos_x_in = sat48(50'(pos_x_ff) + 50'(term));
               issued_in = 1'b0;
               state_in = fdo_pkg::ST_MUL_Y;
            end
         end
         fdo_pkg::ST_MUL_Y: begin
            mul_req.a = fdo_pkg::MUL_A_W'(d_mag);
            mul_req.b = fdo_pkg::MUL_B_W'(sin_mag);
            if (mul_done) begin
               r48 = cap48(mul_prod >> 32);
               r49 = $signed({1'b0, r48});
               term = (d_ff[48] ^ sin_ff[fdo_pkg::CS_W-1]) ? -r49 : r49;
               pos_y_in = sat48(50'(pos_y_ff) + 50'(term));
               head_in = sat48(50'(head_ff) + 50'(dth_ff));
               issued_in = 1'b0;
               state_in = fdo_pkg::ST_OUT;
            end
         end
         fdo_pkg::ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_time_in = time_ff;
               rsp_x_in = pos_x_ff;
               rsp_y_in = pos_y_ff;
               rsp_head_in = head_ff;
               state_in = fdo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fdo_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pose_time_ms = rsp_time_ff;
   assign rsp_pose_x = rsp_x_ff;
   assign rsp_pose_y = rsp_y_ff;
   assign rsp_heading = rsp_head_ff;

   `FDO_ASSERT_NEXT(a_prime_word, clock, reset, req_valid && !req_stall && !have_prev_ff, have_prev_ff && state_ff == fdo_pkg::ST_IDLE)
   `FDO_ASSERT_NEXT(a_word_starts, clock, reset, req_valid && !req_stall && have_prev_ff, state_ff == fdo_pkg::ST_SUM)
   `FDO_ASSERT_SAME(a_rsp_from_out, clock, reset, $rose(rsp_valid), $past(state_ff) == fdo_pkg::ST_OUT)

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;
   localparam logic [63:0] CAP48 = 64'hFFFF_FFFF_FFFF;
   localparam longint MAX47 = 64'sh7FFF_FFFF_FFFF;
   localparam longint MIN47 = -64'sh8000_0000_0000;
   localparam longint PI_Q = 64'sd13493037705;
   localparam longint TWO_PI_Q = 64'sd26986075409;
   localparam longint HALF_PI_Q = 64'sd6746518852;
   localparam longint GAIN_Q = 64'sd2608131496;
   localparam int SETTLE_CYCLES = 100;

   typedef struct {
      logic [31:0]        ts;
      logic signed [31:0] fl, fr, rl, rr;
   } sample_type;

   typedef struct {
      logic [31:0] ts;
      logic [47:0] x, y, h;
   } pose_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [31:0]        req_timestamp_ms;
   logic signed [31:0] req_front_left_ticks;
   logic signed [31:0] req_front_right_ticks;
   logic signed [31:0] req_rear_left_ticks;
   logic signed [31:0] req_rear_right_ticks;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [31:0]        rsp_pose_time_ms;
   logic signed [47:0] rsp_pose_x;
   logic signed [47:0] rsp_pose_y;
   logic signed [47:0] rsp_heading;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [31:0]        csr_wdata;

   four_wheel_diff_drive_odometry_unit u_dut (.*);

   // odometry state mirrored in the bench
   logic [31:0] mpt_cfg;
   logic [31:0] ivw_cfg;
   logic        primed;
   logic [31:0] last_ticks [4];
   longint      odo_x, odo_y, odo_h;

   sample_type pending_samples[$];
   pose_type   expected_poses[$];
   int         mismatch_count;
   int         poses_seen;

   // cumulative encoder counts used by the stimulus
   logic [31:0] enc [4];
   logic [31:0] stamp;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh,
                                                  logic [63:0] cap);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> sh;
      if (p > {64'd0, cap}) return cap;
      return p[63:0];
   endfunction

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint signed_scaled(longint a, longint b, int sh);
      longint r;
      r = longint'(scaled_product(magnitude(a), magnitude(b), sh, CAP48));
      return ((a < 0) != (b < 0)) ? -r : r;
   endfunction

   function automatic longint clamp48(longint v);
      if (v > MAX47) return MAX47;
      if (v < MIN47) return MIN47;
      return v;
   endfunction

   // arctangent of 2^-i by power series, Q.32
   function automatic longint arctan_step(int i);
      longint sum;
      longint term;
      sum = 0;
      if (i == 0) return 64'sd3373259426;
      for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
         term = longint'((64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1));
         sum = (k & 1) ? sum - term : sum + term;
      end
      return longint'((64'(sum) + (64'd1 << 27)) >> 28);
   endfunction

   task automatic rotate_heading(input longint angle, output longint c, output longint s);
      longint r, x, y, xs, ys, a;
      logic   flip;
      r = angle % TWO_PI_Q;
      x = GAIN_Q;
      y = 0;
      flip = 1'b0;
      if (r < 0) r += TWO_PI_Q;
      if (r > PI_Q) r -= TWO_PI_Q;
      if (r > HALF_PI_Q) begin
         r -= PI_Q;
         flip = 1'b1;
      end else if (r < -HALF_PI_Q) begin
         r += PI_Q;
         flip = 1'b1;
      end
      for (int i = 0; i < fdo_pkg::CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         a = arctan_step(i);
         if (r >= 0) begin
            x -= ys;
            y += xs;
            r -= a;
         end else begin
            x += ys;
            y -= xs;
            r += a;
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint tick_delta(logic [31:0] cur, logic [31:0] prev);
      logic signed [31:0] dv;
      dv = cur - prev;
      return longint'(dv);
   endfunction

   task automatic advance_pose(input sample_type smp);
      logic [31:0] cur [4];
      longint      sl, sr, dd, travel, dth, mid, c, s;
      logic [63:0] p;
      cur[0] = smp.fl;
      cur[1] = smp.fr;
      cur[2] = smp.rl;
      cur[3] = smp.rr;
      if (!primed) begin
         last_ticks = cur;
         odo_x = 0;
         odo_y = 0;
         odo_h = 0;
         primed = 1'b1;
         return;
      end
      sl = tick_delta(cur[0], last_ticks[0]) + tick_delta(cur[2], last_ticks[2]);
      sr = tick_delta(cur[1], last_ticks[1]) + tick_delta(cur[3], last_ticks[3]);
      last_ticks = cur;
      travel = signed_scaled(sl + sr, longint'({32'd0, mpt_cfg}), 18);
      dd = sr - sl;
      p = magnitude(dd) * {32'd0, ivw_cfg};
      dth = longint'(scaled_product(p, {32'd0, mpt_cfg}, 17, CAP48));
      if (dd < 0) dth = -dth;
      mid = odo_h + (dth >>> 1);
      rotate_heading(mid, c, s);
      odo_x = clamp48(odo_x + signed_scaled(travel, c, 32));
      odo_y = clamp48(odo_y + signed_scaled(travel, s, 32));
      odo_h = clamp48(odo_h + dth);
      expected_poses.push_back('{smp.ts, odo_x[47:0], odo_y[47:0], odo_h[47:0]});
   endtask

   // sender: bursts of random length with random gaps
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      sample_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 1;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall)
            advance_pose('{req_timestamp_ms, req_front_left_ticks, req_front_right_ticks,
                           req_rear_left_ticks, req_rear_right_ticks});
         if (req_valid && req_stall) begin
            // hold the word
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            nxt = pending_samples.pop_front();
            req_valid <= 1'b1;
            req_timestamp_ms <= nxt.ts;
            req_front_left_ticks <= nxt.fl;
            req_front_right_ticks <= nxt.fr;
            req_rear_left_ticks <= nxt.rl;
            req_rear_right_ticks <= nxt.rr;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall modes plus one long hold-off
   int stall_mode;
   int mode_left;
   int hold_left;
   logic held_once;

   always @(posedge clock) begin
      pose_type want;
      logic     stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= 0;
         mode_left <= 0;
         hold_left <= 0;
         held_once <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            poses_seen <= poses_seen + 1;
            if (expected_poses.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected pose word, time_ms %0d", rsp_pose_time_ms);
            end else begin
               want = expected_poses.pop_front();
               if (rsp_pose_time_ms !== want.ts || rsp_pose_x !== want.x ||
                   rsp_pose_y !== want.y || rsp_heading !== want.h) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("pose mismatch: exp t=%0d x=%h y=%h h=%h got t=%0d x=%h y=%h h=%h",
                              want.ts, want.x, want.y, want.h, rsp_pose_time_ms,
                              rsp_pose_x, rsp_pose_y, rsp_heading);
               end
            end
         end
         if (!held_once && poses_seen == 300) begin
            held_once <= 1'b1;
            hold_left <= 800;
         end
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            stall_next = 1'b1;
         end else begin
            unique case (stall_mode)
               0: stall_next = 1'b0;
               1: stall_next = ($urandom_range(0, 9) < 3);
               default: stall_next = ($urandom_range(0, 9) < 7);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == fdo_pkg::CSR_METERS_PER_TICK) mpt_cfg = data;
      else if (idx == fdo_pkg::CSR_INV_WHEELBASE) ivw_cfg = {8'd0, data[23:0]};
      csr_valid <= 1'b0;
   endtask

   task automatic push_delta(input logic [31:0] dfl, input logic [31:0] dfr,
                             input logic [31:0] drl, input logic [31:0] drr);
      enc[0] += dfl;
      enc[1] += dfr;
      enc[2] += drl;
      enc[3] += drr;
      stamp += $urandom_range(1, 50);
      pending_samples.push_back('{stamp, enc[0], enc[1], enc[2], enc[3]});
   endtask

   function automatic logic [31:0] small_delta();
      return $urandom_range(0, 4000) - 2000;
   endfunction

   task automatic drain();
      while (pending_samples.size() > 0 || req_valid || expected_poses.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_samples(input int n);
      logic [31:0] base;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: push_delta($urandom, $urandom, $urandom, $urandom);
            1: begin
               // pure rotation
               base = small_delta();
               push_delta(-base, base, -base, base);
            end
            2: begin
               enc[0] = $urandom;
               enc[1] = $urandom;
               enc[2] = $urandom;
               enc[3] = $urandom;
               stamp = $urandom;
               pending_samples.push_back('{stamp, enc[0], enc[1], enc[2], enc[3]});
            end
            default: begin
               base = small_delta();
               push_delta(base + $urandom_range(0, 60), base + $urandom_range(0, 60),
                          base + $urandom_range(0, 60), base + $urandom_range(0, 60));
            end
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_timestamp_ms = '0;
      req_front_left_ticks = '0;
      req_front_right_ticks = '0;
      req_rear_left_ticks = '0;
      req_rear_right_ticks = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mpt_cfg = fdo_pkg::MPT_RESET;
      ivw_cfg = {8'd0, fdo_pkg::IVW_RESET};
      primed = 1'b0;
      odo_x = 0;
      odo_y = 0;
      odo_h = 0;
      mismatch_count = 0;
      poses_seen = 0;
      stamp = 32'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first word primes only, then extremes at reset settings
      enc[0] = 32'h7FFF_FFFF;
      enc[1] = 32'h8000_0000;
      enc[2] = 32'h0;
      enc[3] = 32'hFFFF_FFFF;
      pending_samples.push_back('{32'd0, enc[0], enc[1], enc[2], enc[3]});
      pending_samples.push_back('{32'hFFFF_FFFF, enc[0], enc[1], enc[2], enc[3]});
      push_delta(1000, 1000, 1000, 1000);
      push_delta(-1000, 1000, -1000, 1000);
      push_delta(1000, -1000, 1000, -1000);
      push_delta(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_delta(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_delta(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      push_delta(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      push_delta(-5, -5, -5, -5);
      drain();

      // largest scales: heading clamp and position saturation
      csr_write(fdo_pkg::CSR_METERS_PER_TICK, 32'hFFFF_FFFF);
      csr_write(fdo_pkg::CSR_INV_WHEELBASE, 32'h00FF_FFFF);
      for (int i = 0; i < 4; i++)
         push_delta(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      for (int i = 0; i < 4; i++)
         push_delta(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      for (int i = 0; i < 4; i++)
         push_delta(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      random_samples(250);
      drain();

      // smallest scales, writes to unused indexes must be ignored
      csr_write(fdo_pkg::CSR_METERS_PER_TICK, 32'd0);
      csr_write(fdo_pkg::CSR_INV_WHEELBASE, 32'hFF00_0001);
      csr_write(CSR_SPARE_A, $urandom);
      csr_write(CSR_SPARE_B, $urandom);
      random_samples(200);
      drain();

      csr_write(fdo_pkg::CSR_METERS_PER_TICK, fdo_pkg::MPT_RESET);
      csr_write(fdo_pkg::CSR_INV_WHEELBASE, {8'd0, fdo_pkg::IVW_RESET});
      random_samples(450);
      drain();

      // zero wheelbase reciprocal: no heading change
      csr_write(fdo_pkg::CSR_INV_WHEELBASE, 32'd0);
      csr_write(fdo_pkg::CSR_METERS_PER_TICK, $urandom);
      random_samples(150);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         csr_write(fdo_pkg::CSR_METERS_PER_TICK, $urandom);
         csr_write(fdo_pkg::CSR_INV_WHEELBASE, $urandom);
         random_samples(180);
         drain();
      end

      if (mismatch_count == 0 && expected_poses.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
